### hw/rtl/ebl_pkg.sv
// Shared types and constants for the escaped byte link.
package ebl_pkg;

  localparam int unsigned FifoDepthDefault = 64;

  localparam logic [7:0] IdleByte   = 8'h00;
  localparam logic [7:0] EscapeMark = 8'h01;

  typedef enum logic [1:0] {
    OP_HOST_WRITE = 2'd0,
    OP_HOST_READ  = 2'd1,
    OP_LINK_SLOT  = 2'd2,
    OP_UNUSED     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_SLOT,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] host_byte;
    logic [7:0] wire_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] wire_out;
    logic [7:0] read_data;
    logic       read_valid;
    logic       write_accepted;
    logic       rx_stored;
    logic       rx_dropped;
  } out_beat_t;

  typedef struct packed {
    cmd_e       kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage

### hw/rtl/escaped_byte_link_with_fifos.sv
// Top level of the escaped byte link with transmit and receive FIFOs.
// Accepted beats pass through the command queue and the registered result stage.
// Throughput: one beat per cycle while the output is not stalled, set by the execute stage.
// The two-entry command queue lets the input side keep accepting while a result is stalled.
// Reset clears all pointers, counts, escape state and valid flags; FIFO storage is not cleared.
module escaped_byte_link_with_fifos import ebl_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  cmd_head_t head;
  logic      pop;

  ebl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  ebl_back #(
    .FifoDepth (FifoDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_beat_o.rx_stored && out_beat_o.rx_dropped))
    else $error("Slot both stored and dropped a byte.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.read_valid |-> out_beat_o.read_data == 8'd0)
    else $error("Read data is nonzero without a valid read.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.read_valid || out_beat_o.write_accepted)
      |-> out_beat_o.wire_out == 8'd0 && !out_beat_o.rx_stored && !out_beat_o.rx_dropped)
    else $error("Host access beat carries link slot results.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("Command queue popped while empty.");

endmodule

### hw/rtl/ebl_front.sv
// Front part: classifies accepted beats into commands and queues them.
module ebl_front import ebl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output cmd_head_t head_o,
  input  logic      pop_i
);

  localparam int unsigned QueueDepth = 2;

  cmd_t       queue_q [QueueDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  cmd_t       cmd_new;

  always_comb begin
    cmd_new.data = in_beat_i.host_byte;
    case (op_e'(in_beat_i.operation))
      OP_HOST_WRITE: cmd_new.kind = CMD_WRITE;
      OP_HOST_READ:  cmd_new.kind = CMD_READ;
      OP_LINK_SLOT: begin
        cmd_new.kind = CMD_SLOT;
        cmd_new.data = in_beat_i.wire_in;
      end
      default:       cmd_new.kind = CMD_NOP;
    endcase
  end

  assign in_stall_o = (count_q == 2'(QueueDepth));
  assign push       = in_valid_i && !in_stall_o;

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.cmd   = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### hw/rtl/ebl_back.sv
// Back part: transmit and receive FIFOs, escape codec and result register.
module ebl_back import ebl_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_head_t head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  localparam int unsigned AW = $clog2(FifoDepth);
  localparam int unsigned CW = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic       wire_from_mem;
    logic [7:0] wire_direct;
    logic       read_valid;
    logic       write_accepted;
    logic       rx_stored;
    logic       rx_dropped;
  } res_t;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] ptr);
    next_ptr = (ptr == AW'(FifoDepth - 1)) ? '0 : ptr + 1'b1;
  endfunction

  logic [7:0]    tx_mem [FifoDepth];
  logic [7:0]    rx_mem [FifoDepth];
  logic [7:0]    tx_rd_q, rx_rd_q;

  logic [AW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [AW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [CW-1:0] tx_cnt_q, tx_cnt_d, rx_cnt_q, rx_cnt_d;
  logic [7:0]    pend_q, pend_d, pend_eff;
  logic          fold_q, fold_d;
  logic          armed_q, armed_d;
  logic          out_valid_q, out_valid_d;
  res_t          res_q, res_d;

  logic          exec;
  logic          tx_wr, tx_rd, rx_wr, rx_rd;
  logic [7:0]    rx_data;
  logic          rx_have;

  assign exec  = head_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o = exec;

  assign pend_eff = fold_q ? ((tx_rd_q[7:1] == 7'd0) ? tx_rd_q + 8'd1 : 8'd0) : pend_q;

  always_comb begin
    tx_head_d   = tx_head_q;
    tx_tail_d   = tx_tail_q;
    tx_cnt_d    = tx_cnt_q;
    rx_head_d   = rx_head_q;
    rx_tail_d   = rx_tail_q;
    rx_cnt_d    = rx_cnt_q;
    pend_d      = pend_q;
    fold_d      = fold_q;
    armed_d     = armed_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    tx_wr       = 1'b0;
    tx_rd       = 1'b0;
    rx_wr       = 1'b0;
    rx_rd       = 1'b0;
    rx_data     = head_i.cmd.data;
    rx_have     = 1'b0;

    if (exec) begin
      out_valid_d = 1'b1;
      res_d       = '0;
      pend_d      = pend_eff;
      fold_d      = 1'b0;
      case (head_i.cmd.kind)
        CMD_WRITE: begin
          if (tx_cnt_q < CW'(FifoDepth)) begin
            tx_wr                = 1'b1;
            tx_tail_d            = next_ptr(tx_tail_q);
            tx_cnt_d             = tx_cnt_q + 1'b1;
            res_d.write_accepted = 1'b1;
          end
        end
        CMD_READ: begin
          if (rx_cnt_q != '0) begin
            rx_rd            = 1'b1;
            rx_head_d        = next_ptr(rx_head_q);
            rx_cnt_d         = rx_cnt_q - 1'b1;
            res_d.read_valid = 1'b1;
          end
        end
        CMD_SLOT: begin
          if (pend_eff != 8'd0) begin
            res_d.wire_direct = pend_eff;
            pend_d            = 8'd0;
          end else if (tx_cnt_q != '0) begin
            tx_rd               = 1'b1;
            tx_head_d           = next_ptr(tx_head_q);
            tx_cnt_d            = tx_cnt_q - 1'b1;
            fold_d              = 1'b1;
            res_d.wire_from_mem = 1'b1;
          end else begin
            res_d.wire_direct = IdleByte;
          end

          if (head_i.cmd.data != IdleByte) begin
            if (armed_q) begin
              rx_data = head_i.cmd.data - 8'd1;
              rx_have = 1'b1;
              armed_d = 1'b0;
            end else if (head_i.cmd.data == EscapeMark) begin
              armed_d = 1'b1;
            end else begin
              rx_have = 1'b1;
            end
          end

          if (rx_have) begin
            if (rx_cnt_q < CW'(FifoDepth)) begin
              rx_wr           = 1'b1;
              rx_tail_d       = next_ptr(rx_tail_q);
              rx_cnt_d        = rx_cnt_q + 1'b1;
              res_d.rx_stored = 1'b1;
            end else begin
              res_d.rx_dropped = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (tx_wr) begin
      tx_mem[tx_tail_q] <= head_i.cmd.data;
    end
    if (tx_rd) begin
      tx_rd_q <= tx_mem[tx_head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_wr) begin
      rx_mem[rx_tail_q] <= rx_data;
    end
    if (rx_rd) begin
      rx_rd_q <= rx_mem[rx_head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_head_q   <= '0;
      tx_tail_q   <= '0;
      tx_cnt_q    <= '0;
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      rx_cnt_q    <= '0;
      pend_q      <= 8'd0;
      fold_q      <= 1'b0;
      armed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tx_head_q   <= tx_head_d;
      tx_tail_q   <= tx_tail_d;
      tx_cnt_q    <= tx_cnt_d;
      rx_head_q   <= rx_head_d;
      rx_tail_q   <= rx_tail_d;
      rx_cnt_q    <= rx_cnt_d;
      pend_q      <= pend_d;
      fold_q      <= fold_d;
      armed_q     <= armed_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    out_beat_o.wire_out = res_q.wire_direct;
    if (res_q.wire_from_mem) begin
      out_beat_o.wire_out = (tx_rd_q[7:1] == 7'd0) ? EscapeMark : tx_rd_q;
    end
    out_beat_o.read_data      = res_q.read_valid ? rx_rd_q : 8'd0;
    out_beat_o.read_valid     = res_q.read_valid;
    out_beat_o.write_accepted = res_q.write_accepted;
    out_beat_o.rx_stored      = res_q.rx_stored;
    out_beat_o.rx_dropped     = res_q.rx_dropped;
  end

endmodule
